/* src/ugcb_pkg.sv */
// Shared constants, codes and controller/datapath types of the grid binning block.
package ugcb_pkg;

    localparam int MAX_CELLS = 16;
    localparam int AXIS_BITS = 4;
    localparam int CELL_BITS = 3 * AXIS_BITS;
    localparam int CAP       = 8;
    localparam int SLOT_BITS = 3;
    localparam int FILL_BITS = 4;
    localparam int ID_BITS   = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // request types
    localparam logic [2:0] REQ_INSERT    = 3'd0;
    localparam logic [2:0] REQ_LIST_POS  = 3'd1;
    localparam logic [2:0] REQ_LIST_CELL = 3'd2;
    localparam logic [2:0] REQ_MEMBER    = 3'd3;
    localparam logic [2:0] REQ_CLEAR     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z   = 3'd6;

    // kind of result loaded into the output register
    typedef enum logic [2:0] {
        EMIT_ZERO,
        EMIT_INSERT,
        EMIT_EMPTY,
        EMIT_ITEM,
        EMIT_FOUND
    } t_emit;

    typedef struct packed {
        logic  capture;
        logic  div_start;
        logic  axis_next;
        logic  fill_rd;
        logic  fill_wr;
        logic  slot_rd;
        logic  k_clr;
        logic  k_inc;
        logic  found_upd;
        logic  clr_start;
        logic  clr_step;
        logic  emit;
        t_emit emit_kind;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req_in;
        logic [2:0] req;
        logic       div_done;
        logic       axis_last;
        logic       fill_full;
        logic       list_empty;
        logic       slot_last;
        logic       out_busy;
        logic       clr_last;
    } t_sts;

    // last usable cell index for a cell count register, saturated to [1, MAX_CELLS]
    function automatic logic [AXIS_BITS-1:0] eff_last(input logic [4:0] n);
        logic [AXIS_BITS-1:0] r;
        if (n == 5'd0) begin
            r = '0;
        end else if (n > 5'(MAX_CELLS)) begin
            r = AXIS_BITS'(MAX_CELLS - 1);
        end else begin
            r = AXIS_BITS'(n - 5'd1);
        end
        return r;
    endfunction

endpackage

/* src/uniform_grid_cell_binning.sv */
// Top level of the uniform grid cell binning block.
//
// Requests enter on the s_axis channel: tuser carries the request type,
// tdata the positions, cell indices and particle id. Results leave on the
// m_axis channel from an output register: tuser flags a listed id, tlast
// marks the final result of a request. Configuration is a write port
// (enable, register index, data) taken whenever the enable is high.
// One request is worked on at a time; the next one is taken while the
// last result still waits in the output register.
// A position request runs three divisions on the shared divider, one per
// axis, then a fill-count read, before its insert result or its first id.
// Listing and membership read the stored ids one by one from the slot
// memory; a request by cell indices skips the divisions.
// Clear sweeps the 4096 fill counts, one a cycle, then gives one result.
// After reset the same sweep runs with tready low.
// A stalled receiver holds the output register; the block waits on it
// before loading the next result.
module uniform_grid_cell_binning (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ugcb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ugcb_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // pos_x, pos_y, pos_z, cell_x, cell_y, cell_z, particle_id
    input  logic [159:0]                   i_s_axis_tdata,
    // req_type
    input  logic [2:0]                     i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // item_id, found, overflow, hit_x, hit_y, hit_z, two zero bits
    output logic [31:0]                    o_m_axis_tdata,
    // item_valid
    output logic                           o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);
    import ugcb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ugcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_ready    (o_s_axis_tready)
    );

    ugcb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser),
        .o_m_tlast   (o_m_axis_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule

/* src/ugcb_div.sv */
// Iterative divider giving a saturated 4-bit quotient of offset by cell size.
module ugcb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [30:0] i_den,
    output logic        o_done,
    output logic [3:0]  o_q
);
    import ugcb_pkg::*;

    logic        r_busy, r_done;
    logic [1:0]  r_step;
    logic [31:0] r_rem;
    logic [3:0]  r_q;
    logic        r_sat;
    logic [34:0] w_sub;
    logic        w_ge;

    // compare remainder against shifted divisor
    assign w_sub = {4'b0, i_den} << r_step;
    assign w_ge  = {3'b0, r_rem} >= w_sub;

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == 2'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // one quotient bit per cycle, high bit first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= 2'd3;
            r_rem  <= i_num;
            r_q    <= '0;
            r_sat  <= {3'b0, i_num} >= {i_den, 4'b0};
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem        <= r_rem - w_sub[31:0];
                r_q[r_step]  <= 1'b1;
            end
            r_step <= r_step - 2'd1;
        end
    end

    assign o_done = r_done;
    assign o_q    = r_sat ? 4'hF : r_q;

endmodule

/* src/ugcb_dp.sv */
// Datapath: request and configuration registers, cell memories, output register.
module ugcb_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ugcb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ugcb_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [159:0]                  i_s_tdata,
    input  logic [2:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,
    output logic                          o_m_tuser,
    output logic                          o_m_tlast,
    input  ugcb_pkg::t_cmd                i_cmd,
    output ugcb_pkg::t_sts                o_sts
);
    import ugcb_pkg::*;

    // configuration
    logic [31:0] r_min_x, r_min_y, r_min_z;
    logic [30:0] r_cs;
    logic [4:0]  r_cells_x, r_cells_y, r_cells_z;

    // captured request
    logic [2:0]  r_req;
    logic [31:0] r_pos_x, r_pos_y, r_pos_z;
    logic [15:0] r_cx, r_cy, r_cz;
    logic [ID_BITS-1:0] r_pid;

    // work registers
    logic [1:0]           r_axis;
    logic [AXIS_BITS-1:0] r_hx, r_hy, r_hz;
    logic [FILL_BITS-1:0] r_fill_q;
    logic [ID_BITS-1:0]   r_id_q;
    logic [SLOT_BITS-1:0] r_k;
    logic                 r_found;
    logic [CELL_BITS-1:0] r_clr;

    // output register
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic        r_out_user, r_out_last;

    logic [FILL_BITS-1:0] mem_fill [1 << CELL_BITS];
    logic [ID_BITS-1:0]   mem_ids  [1 << (CELL_BITS + SLOT_BITS)];

    logic [AXIS_BITS-1:0] w_mx, w_my, w_mz, w_m, w_q, w_hit;
    logic [31:0] w_pos, w_org, w_num;
    logic [32:0] w_diff;
    logic [30:0] w_den;
    logic        w_div_done;
    logic        w_pos_type, w_cell_ok, w_out_busy, w_slot_last, w_fill_full;
    logic [CELL_BITS-1:0] w_addr;
    logic        w_fill_we;
    logic [CELL_BITS-1:0] w_fill_wa;
    logic [FILL_BITS-1:0] w_fill_wd;
    logic [ID_BITS-1:0]   w_o_id;
    logic [AXIS_BITS-1:0] w_ox, w_oy, w_oz;
    logic        w_o_found, w_o_ovf, w_o_valid, w_o_last;

    assign w_mx = eff_last(r_cells_x);
    assign w_my = eff_last(r_cells_y);
    assign w_mz = eff_last(r_cells_z);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x   <= '0;
            r_min_y   <= '0;
            r_min_z   <= '0;
            r_cs      <= 31'd65536;
            r_cells_x <= 5'd1;
            r_cells_y <= 5'd1;
            r_cells_z <= 5'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_X:     r_min_x   <= i_cfg_wdata;
                CFG_MIN_Y:     r_min_y   <= i_cfg_wdata;
                CFG_MIN_Z:     r_min_z   <= i_cfg_wdata;
                CFG_CELL_SIZE: r_cs      <= i_cfg_wdata[30:0];
                CFG_CELLS_X:   r_cells_x <= i_cfg_wdata[4:0];
                CFG_CELLS_Y:   r_cells_y <= i_cfg_wdata[4:0];
                CFG_CELLS_Z:   r_cells_z <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // capture request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_s_tuser;
            r_pos_x <= i_s_tdata[31:0];
            r_pos_y <= i_s_tdata[63:32];
            r_pos_z <= i_s_tdata[95:64];
            r_cx    <= i_s_tdata[111:96];
            r_cy    <= i_s_tdata[127:112];
            r_cz    <= i_s_tdata[143:128];
            r_pid   <= i_s_tdata[159:144];
        end
    end

    // select axis operands for the shared divider
    always_comb begin
        case (r_axis)
            2'd0:    begin w_pos = r_pos_x; w_org = r_min_x; w_m = w_mx; end
            2'd1:    begin w_pos = r_pos_y; w_org = r_min_y; w_m = w_my; end
            default: begin w_pos = r_pos_z; w_org = r_min_z; w_m = w_mz; end
        endcase
    end

    // negative offset divides as zero
    assign w_diff = {w_pos[31], w_pos} - {w_org[31], w_org};
    assign w_num  = w_diff[32] ? 32'd0 : w_diff[31:0];
    assign w_den  = (r_cs == 31'd0) ? 31'd1 : r_cs;

    ugcb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    assign w_hit = (w_q > w_m) ? w_m : w_q;

    // step through axes, hold clamped indices
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= 2'd0;
        end else if (i_cmd.capture) begin
            r_axis <= 2'd0;
        end else if (i_cmd.axis_next) begin
            r_axis <= r_axis + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.axis_next) begin
            case (r_axis)
                2'd0:    r_hx <= w_hit;
                2'd1:    r_hy <= w_hit;
                default: r_hz <= w_hit;
            endcase
        end
    end

    // cell address and range check
    assign w_pos_type = (r_req == REQ_INSERT) || (r_req == REQ_LIST_POS);
    assign w_cell_ok  = w_pos_type ||
                        (!r_cx[15] && r_cx[14:0] <= {11'b0, w_mx} &&
                         !r_cy[15] && r_cy[14:0] <= {11'b0, w_my} &&
                         !r_cz[15] && r_cz[14:0] <= {11'b0, w_mz});
    assign w_addr = w_pos_type ? {r_hx, r_hy, r_hz}
                               : {r_cx[AXIS_BITS-1:0], r_cy[AXIS_BITS-1:0],
                                  r_cz[AXIS_BITS-1:0]};

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_start) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // fill count memory
    assign w_fill_we = i_cmd.clr_step || i_cmd.fill_wr;
    assign w_fill_wa = i_cmd.clr_step ? r_clr : w_addr;
    assign w_fill_wd = i_cmd.clr_step ? '0 : r_fill_q + 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_fill_we) begin
            mem_fill[w_fill_wa] <= w_fill_wd;
        end
        if (i_cmd.fill_rd) begin
            r_fill_q <= mem_fill[w_addr];
        end
    end

    // id slot memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_wr) begin
            mem_ids[{w_addr, r_fill_q[SLOT_BITS-1:0]}] <= r_pid;
        end
        if (i_cmd.slot_rd) begin
            r_id_q <= mem_ids[{w_addr, r_k}];
        end
    end

    // slot walk and membership flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.k_clr) begin
            r_k     <= '0;
            r_found <= 1'b0;
        end else begin
            if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.found_upd && r_id_q == r_pid) begin
                r_found <= 1'b1;
            end
        end
    end

    assign w_fill_full = r_fill_q >= FILL_BITS'(CAP);
    assign w_slot_last = ({1'b0, r_k} + 1'b1) == r_fill_q;
    assign w_out_busy  = r_out_valid && !i_m_tready;

    // result fields
    assign w_o_valid = i_cmd.emit_kind == EMIT_ITEM;
    assign w_o_id    = w_o_valid ? r_id_q : '0;
    assign w_o_found = (i_cmd.emit_kind == EMIT_FOUND) && r_found;
    assign w_o_ovf   = (i_cmd.emit_kind == EMIT_INSERT) && w_fill_full;
    assign w_o_last  = !w_o_valid || w_slot_last;
    assign w_ox      = w_pos_type ? r_hx : '0;
    assign w_oy      = w_pos_type ? r_hy : '0;
    assign w_oz      = w_pos_type ? r_hz : '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {2'b0, w_oz, w_oy, w_ox, w_o_ovf, w_o_found, w_o_id};
            r_out_user <= w_o_valid;
            r_out_last <= w_o_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;
    assign o_m_tlast  = r_out_last;

    assign o_sts.req_in     = i_s_tuser;
    assign o_sts.req        = r_req;
    assign o_sts.div_done   = w_div_done;
    assign o_sts.axis_last  = r_axis == 2'd2;
    assign o_sts.fill_full  = w_fill_full;
    assign o_sts.list_empty = !w_cell_ok || (r_fill_q == '0);
    assign o_sts.slot_last  = w_slot_last;
    assign o_sts.out_busy   = w_out_busy;
    assign o_sts.clr_last   = &r_clr;

    // checks
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !w_out_busy)
        else $error("result loaded while output register stalled");
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_wr |-> !w_fill_full && w_pos_type)
        else $error("insert written into a full cell");
    a_slot_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.slot_rd |-> ({1'b0, r_k} < r_fill_q))
        else $error("slot read beyond fill count");

endmodule

/* src/ugcb_ctrl.sv */
// Controller state machine sequencing each request over the datapath.
module ugcb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  ugcb_pkg::t_sts i_sts,
    output ugcb_pkg::t_cmd o_cmd,
    output logic           o_ready
);
    import ugcb_pkg::*;

    typedef enum logic [10:0] {
        S_INIT    = 11'b00000000001,
        S_IDLE    = 11'b00000000010,
        S_DIV_GO  = 11'b00000000100,
        S_DIV_WT  = 11'b00000001000,
        S_FILL_RD = 11'b00000010000,
        S_FILL_WT = 11'b00000100000,
        S_SLOT_RD = 11'b00001000000,
        S_SLOT_WT = 11'b00010000000,
        S_FOUND   = 11'b00100000000,
        S_CLR     = 11'b01000000000,
        S_ZERO    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    case (i_sts.req_in)
                        REQ_INSERT, REQ_LIST_POS: n_state = S_DIV_GO;
                        REQ_LIST_CELL, REQ_MEMBER: n_state = S_FILL_RD;
                        REQ_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_state = S_CLR;
                        end
                        default: n_state = S_ZERO;
                    endcase
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_WT;
            end
            S_DIV_WT: begin
                if (i_sts.div_done) begin
                    o_cmd.axis_next = 1'b1;
                    n_state = i_sts.axis_last ? S_FILL_RD : S_DIV_GO;
                end
            end
            S_FILL_RD: begin
                o_cmd.fill_rd = 1'b1;
                n_state = S_FILL_WT;
            end
            S_FILL_WT: begin
                o_cmd.k_clr = 1'b1;
                case (i_sts.req)
                    REQ_INSERT: begin
                        if (!i_sts.out_busy) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = EMIT_INSERT;
                            o_cmd.fill_wr   = !i_sts.fill_full;
                            n_state = S_IDLE;
                        end
                    end
                    REQ_MEMBER: begin
                        n_state = i_sts.list_empty ? S_FOUND : S_SLOT_RD;
                    end
                    default: begin
                        if (!i_sts.list_empty) begin
                            n_state = S_SLOT_RD;
                        end else if (!i_sts.out_busy) begin
                            o_cmd.emit      = 1'b1;
                            o_cmd.emit_kind = EMIT_EMPTY;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_SLOT_RD: begin
                o_cmd.slot_rd = 1'b1;
                n_state = S_SLOT_WT;
            end
            S_SLOT_WT: begin
                if (i_sts.req == REQ_MEMBER) begin
                    o_cmd.found_upd = 1'b1;
                    o_cmd.k_inc     = 1'b1;
                    n_state = i_sts.slot_last ? S_FOUND : S_SLOT_RD;
                end else if (!i_sts.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_ITEM;
                    o_cmd.k_inc     = 1'b1;
                    n_state = i_sts.slot_last ? S_IDLE : S_SLOT_RD;
                end
            end
            S_FOUND: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_FOUND;
                    n_state = S_IDLE;
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_ZERO;
            end
            S_ZERO: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_kind = EMIT_ZERO;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the uniform grid cell binning block.
`timescale 1ns / 1ps

module tb_top;
    import ugcb_pkg::*;

    typedef struct packed {
        logic [2:0]  req;
        logic [31:0] px, py, pz;
        logic [15:0] cx, cy, cz;
        logic [15:0] pid;
    } t_request;

    typedef struct packed {
        logic [15:0] id;
        logic        valid;
        logic        found;
        logic        ovf;
        logic [3:0]  hx, hy, hz;
        logic        last;
    } t_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_wdata = '0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [159:0] i_s_axis_tdata = '0;
    logic [2:0]   i_s_axis_tuser = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [31:0]  o_m_axis_tdata;
    logic         o_m_axis_tuser;
    logic         o_m_axis_tlast;

    uniform_grid_cell_binning dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the grid and its settings
    logic [31:0] org_x, org_y, org_z;
    logic [30:0] edge_len;
    logic [4:0]  ncx, ncy, ncz;
    logic [3:0]  fill_of [4096];
    logic [15:0] ids_of [4096][8];

    t_request pending_req[$];
    t_result  expected_res[$];
    int       errors = 0;
    int       n_sent = 0;
    int       n_seen = 0;

    task automatic expect_res(t_result r);
        expected_res = {expected_res, r};
    endtask

    task automatic queue_req(t_request q);
        pending_req = {pending_req, q};
    endtask

    // split a request from its bus fields, lowest tdata field first
    function automatic t_request unpack_req(logic [2:0] u, logic [159:0] d);
        t_request r;
        r.req = u;
        r.px  = d[31:0];
        r.py  = d[63:32];
        r.pz  = d[95:64];
        r.cx  = d[111:96];
        r.cy  = d[127:112];
        r.cz  = d[143:128];
        r.pid = d[159:144];
        return r;
    endfunction

    function automatic logic [3:0] last_index(logic [4:0] n);
        if (n == 0) return 4'd0;
        if (n > 16) return 4'd15;
        return 4'(n - 1);
    endfunction

    function automatic logic [3:0] bin_axis(logic [31:0] p, logic [31:0] o,
                                            logic [4:0] n);
        longint diff;
        longint cs;
        longint q;
        diff = longint'($signed(p)) - longint'($signed(o));
        cs = (edge_len == 0) ? 1 : longint'(edge_len);
        if (diff < 0) return 4'd0;
        q = diff / cs;
        if (q > longint'(last_index(n))) return last_index(n);
        return 4'(q);
    endfunction

    function automatic bit cell_ok(t_request r);
        return !r.cx[15] && !r.cy[15] && !r.cz[15]
            && r.cx <= 16'(last_index(ncx)) && r.cy <= 16'(last_index(ncy))
            && r.cz <= 16'(last_index(ncz));
    endfunction

    // list a cell's contents into the expectation queue
    task automatic push_listing(int a, bit has, logic [3:0] hx, hy, hz);
        t_result r;
        int n;
        n = has ? fill_of[a] : 0;
        r = '0;
        r.hx = hx; r.hy = hy; r.hz = hz;
        if (n == 0) begin
            r.last = 1'b1;
            expect_res(r);
        end
        for (int k = 0; k < n; k++) begin
            r.id = ids_of[a][k];
            r.valid = 1'b1;
            r.last = (k == n - 1);
            expect_res(r);
        end
    endtask

    task automatic predict_grid(t_request q);
        t_result r;
        logic [3:0] hx, hy, hz;
        int a;
        r = '0;
        r.last = 1'b1;
        case (q.req)
            REQ_INSERT, REQ_LIST_POS: begin
                hx = bin_axis(q.px, org_x, ncx);
                hy = bin_axis(q.py, org_y, ncy);
                hz = bin_axis(q.pz, org_z, ncz);
                a = {hx, hy, hz};
                if (q.req == REQ_LIST_POS) begin
                    push_listing(a, 1'b1, hx, hy, hz);
                    return;
                end
                if (fill_of[a] >= 8) begin
                    r.ovf = 1'b1;
                end else begin
                    ids_of[a][fill_of[a]] = q.pid;
                    fill_of[a]++;
                end
                r.hx = hx; r.hy = hy; r.hz = hz;
            end
            REQ_LIST_CELL: begin
                push_listing({q.cx[3:0], q.cy[3:0], q.cz[3:0]}, cell_ok(q), 0, 0, 0);
                return;
            end
            REQ_MEMBER: begin
                if (cell_ok(q)) begin
                    a = {q.cx[3:0], q.cy[3:0], q.cz[3:0]};
                    for (int k = 0; k < fill_of[a]; k++)
                        if (ids_of[a][k] == q.pid) r.found = 1'b1;
                end
            end
            REQ_CLEAR: foreach (fill_of[i]) fill_of[i] = '0;
            default: ;
        endcase
        expect_res(r);
    endtask

    // sender: bursts of requests separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_grid(unpack_req(i_s_axis_tuser, i_s_axis_tdata));
                n_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_req.size() > 0) begin
                    t_request q;
                    q = pending_req.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser <= q.req;
                    i_s_axis_tdata <= {q.pid, q.cz, q.cy, q.cx, q.pz, q.py, q.px};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern and result checking
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                t_result got;
                t_result want;
                got = '0;
                got.id = o_m_axis_tdata[15:0];
                got.found = o_m_axis_tdata[16];
                got.ovf = o_m_axis_tdata[17];
                got.hx = o_m_axis_tdata[21:18];
                got.hy = o_m_axis_tdata[25:22];
                got.hz = o_m_axis_tdata[29:26];
                got.valid = o_m_axis_tuser;
                got.last = o_m_axis_tlast;
                n_seen++;
                if (expected_res.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    errors++;
                end else begin
                    want = expected_res.pop_front();
                    if (got !== want || o_m_axis_tdata[31:30] !== 2'b00) begin
                        $display("%0t: expected id=%h v=%b f=%b o=%b hit=%h/%h/%h l=%b",
                            $realtime, want.id, want.valid, want.found, want.ovf,
                            want.hx, want.hy, want.hz, want.last);
                        $display("%0t: actual   id=%h v=%b f=%b o=%b hit=%h/%h/%h l=%b",
                            $realtime, got.id, got.valid, got.found, got.ovf,
                            got.hx, got.hy, got.hz, got.last);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: i_m_axis_tready <= 1'b1;
                1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MIN_X:     org_x = v;
            CFG_MIN_Y:     org_y = v;
            CFG_MIN_Z:     org_z = v;
            CFG_CELL_SIZE: edge_len = v[30:0];
            CFG_CELLS_X:   ncx = v[4:0];
            CFG_CELLS_Y:   ncy = v[4:0];
            CFG_CELLS_Z:   ncz = v[4:0];
            default: ;
        endcase
    endtask

    task automatic drain_all();
        while (pending_req.size() > 0 || expected_res.size() > 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        repeat (4200) @(posedge i_clk);
    endtask

    function automatic t_request mk(logic [2:0] t, logic [31:0] x, y, z,
                                    logic [15:0] a, b, c, id);
        return '{t, x, y, z, a, b, c, id};
    endfunction

    // position within the grid, mostly inside, sometimes far outside
    function automatic logic [31:0] some_pos(logic [31:0] o);
        longint cs;
        longint span;
        cs = (edge_len == 0) ? 1 : longint'(edge_len);
        span = cs * 18;
        if ($urandom_range(0, 7) == 0) return $urandom;
        return 32'(longint'($signed(o)) + longint'($urandom_range(0, 32'hFFFF_FFFF)) % span
                   - cs);
    endfunction

    function automatic logic [15:0] some_index();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 17));
    endfunction

    task automatic random_phase(int count, logic [15:0] id_range);
        t_request q;
        for (int i = 0; i < count; i++) begin
            q = mk($urandom_range(0, 7) == 0 ? 3'($urandom_range(0, 7))
                   : 3'($urandom_range(0, 3)),
                   some_pos(org_x), some_pos(org_y), some_pos(org_z),
                   some_index(), some_index(), some_index(),
                   16'($urandom_range(0, id_range)));
            if ($urandom_range(0, 40) == 0) q.req = REQ_CLEAR;
            if ($urandom_range(0, 19) == 0) q.pid = 16'($urandom);
            queue_req(q);
        end
    endtask

    initial begin
        org_x = 0; org_y = 0; org_z = 0;
        edge_len = 31'd65536;
        ncx = 1; ncy = 1; ncz = 1;
        foreach (fill_of[i]) fill_of[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset grid, overflow, extremes, every request kind
        for (int i = 0; i < 9; i++)
            queue_req(mk(REQ_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0,
                         i == 0 ? 16'hFFFF : 16'(i)));
        queue_req(mk(REQ_LIST_POS, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 0, 0));
        queue_req(mk(REQ_LIST_CELL, 0, 0, 0, 0, 0, 0, 0));
        queue_req(mk(REQ_LIST_CELL, 0, 0, 0, 16'h8000, 0, 0, 0));
        queue_req(mk(REQ_LIST_CELL, 0, 0, 0, 0, 16'h7FFF, 0, 0));
        queue_req(mk(REQ_MEMBER, 0, 0, 0, 0, 0, 0, 16'hFFFF));
        queue_req(mk(REQ_MEMBER, 0, 0, 0, 0, 0, 0, 16'h1234));
        queue_req(mk(REQ_MEMBER, 0, 0, 0, 0, 0, 16'h0001, 16'h0001));
        queue_req(mk(3'd5, 0, 0, 0, 0, 0, 0, 0));
        queue_req(mk(3'd7, '1, '1, '1, '1, '1, '1, '1));
        queue_req(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        queue_req(mk(REQ_LIST_CELL, 0, 0, 0, 0, 0, 0, 0));
        drain_all();

        // full-size grid, unit cells at a negative origin
        write_reg(CFG_MIN_X, 32'hFFF8_0000);
        write_reg(CFG_MIN_Y, 32'h0000_0000);
        write_reg(CFG_MIN_Z, 32'h8000_0000);
        write_reg(CFG_CELL_SIZE, 32'h0001_0000);
        write_reg(CFG_CELLS_X, 16);
        write_reg(CFG_CELLS_Y, 16);
        write_reg(CFG_CELLS_Z, 16);
        random_phase(90, 15);
        drain_all();

        // small grid with saturating counts: crowded cells
        write_reg(CFG_CELLS_X, 0);
        write_reg(CFG_CELLS_Y, 31);
        write_reg(CFG_CELLS_Z, 2);
        write_reg(CFG_CELL_SIZE, 0);
        write_reg(CFG_MIN_X, 32'h7FFF_FFFF);
        random_phase(80, 7);
        drain_all();

        // huge cells, mid-size grid
        write_reg(CFG_CELL_SIZE, 32'h7FFF_FFFF);
        write_reg(CFG_CELLS_X, 3);
        write_reg(CFG_CELLS_Y, 5);
        write_reg(CFG_CELLS_Z, 17);
        write_reg(CFG_MIN_X, 32'h8000_0000);
        write_reg(CFG_MIN_Z, 32'h0000_1234);
        random_phase(70, 31);
        drain_all();

        // odd cell size
        write_reg(CFG_CELL_SIZE, 32'h0000_3A7F);
        write_reg(CFG_CELLS_X, 4);
        write_reg(CFG_CELLS_Y, 2);
        write_reg(CFG_CELLS_Z, 4);
        write_reg(CFG_MIN_Y, 32'hFFFF_0001);
        random_phase(70, 63);
        drain_all();

        $display("Covered %0d requests and %0d results over five grid settings,",
                 n_sent, n_seen);
        $display("including overflow, clears, out-of-range cells and saturated counts.");
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
src/ugcb_pkg.sv
src/ugcb_div.sv
src/ugcb_dp.sv
src/ugcb_ctrl.sv
src/uniform_grid_cell_binning.sv
bench/tb_top.sv
